[rtl/core/call_stack_exclusive_time_profiler_unit_defines.svh]
// assertion macros shared by the profiler rtl
// depends on nothing; included by the files that carry assertions
`ifndef CALL_STACK_EXCLUSIVE_TIME_PROFILER_UNIT_DEFINES_SVH
`define CALL_STACK_EXCLUSIVE_TIME_PROFILER_UNIT_DEFINES_SVH

// same-cycle implication, idle during reset
`define CSTP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cstp assertion failed");

// next-cycle implication, idle during reset
`define CSTP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cstp assertion failed");

`endif

[rtl/core/cstp_pkg.sv]
// shared constants, codes and types of the call stack profiler
// depends on nothing
`default_nettype none

package cstp_pkg;

   localparam int NUM_FUNCS   = 128;
   localparam int STACK_DEPTH = 256;

   localparam int CMD_W  = 2;
   localparam int FID_W  = 7;
   localparam int TS_W   = 32;
   localparam int TOT_W  = 32;
   localparam int STAT_W = 2;

   localparam int REQ_TDATA_W = ((FID_W + TS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((FID_W + TOT_W + 7) / 8) * 8;

   localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
   localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FUNC_AW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
   localparam int FRAME_W = 2 * TS_W;

   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DUR  = 4'b0010,
      S_EXCL = 4'b0100,
      S_UPD  = 4'b1000
   } state_type;

   // frame word: start time in the upper half, callee time in the lower
   typedef struct packed {
      logic               en;
      logic [PTR_W-1:0]   addr;
      logic [FRAME_W-1:0] data;
   } frame_wr_type;

   typedef struct packed {
      logic               en;
      logic [FUNC_AW-1:0] addr;
      logic [TOT_W-1:0]   data;
   } total_wr_type;

endpackage

`default_nettype wire

[rtl/core/cstp_frame_mem.sv]
// call stack frame memory: two registered read ports, one write port
// depends on cstp_pkg
`default_nettype none

module cstp_frame_mem (
   input  wire                          clock,
   input  wire                          rd_en,
   input  wire  [cstp_pkg::PTR_W-1:0]   rd_addr_a,
   input  wire  [cstp_pkg::PTR_W-1:0]   rd_addr_b,
   output logic [cstp_pkg::FRAME_W-1:0] rd_data_a,
   output logic [cstp_pkg::FRAME_W-1:0] rd_data_b,
   input  wire  cstp_pkg::frame_wr_type wr
);
   import cstp_pkg::*;

   logic [FRAME_W-1:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

[rtl/core/cstp_total_mem.sv]
// per-function exclusive totals, one registered read port, one write port
// entries read as zero until first written; depends on cstp_pkg
`default_nettype none

module cstp_total_mem (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          rd_en,
   input  wire  [cstp_pkg::FUNC_AW-1:0] rd_addr,
   output logic [cstp_pkg::TOT_W-1:0]   rd_data,
   input  wire  cstp_pkg::total_wr_type wr
);
   import cstp_pkg::*;

   logic [TOT_W-1:0]     mem [NUM_FUNCS];
   logic [NUM_FUNCS-1:0] valid_ff;
   logic [TOT_W-1:0]     rd_word_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

[rtl/core/call_stack_exclusive_time_profiler_unit.sv]
// top level of the call stack exclusive time profiler
// depends on cstp_pkg, cstp_frame_mem, cstp_total_mem and the assertion macro header
`default_nettype none

// usage
// req channel: one word per event. tuser carries the command (start, end,
//   read total; code 3 reads too), tdata the function id and the timestamp.
// rsp channel: exactly one word per request, carrying the function id, its
//   exclusive total after the request and a status flag in tuser (ok, end on
//   an empty stack, start on a full stack). erroneous requests leave the
//   stack and the totals untouched.
// sequencing: a start, read or refused end goes from acceptance to the update
//   step, an end on a non-empty stack passes through the duration and exclusive
//   steps first, and the update step loads the output register; the next
//   request is taken once the previous one has written back; this follows from
//   the read-modify-write of the frame and totals memories and from the end path
//   splitting duration, exclusive time and the saturating adds over three steps.
// the result sits in an output register, so a new request is taken while it
//   waits; if rsp_tready stays low the next result holds in the update step
//   and req_tready drops until the output register frees up.
// reset clears the stack level, the state and the totals (valid bits, no
//   clearing pass); frame contents need no reset as only pushed frames are read.

module call_stack_exclusive_time_profiler_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // func_id [6:0], timestamp [38:7], zero [39]
   input  wire  [cstp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command [1:0]
   input  wire  [cstp_pkg::CMD_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // func_out [6:0], total_time [38:7], zero [39]
   output logic [cstp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [cstp_pkg::STAT_W-1:0]      rsp_tuser
);
   import cstp_pkg::*;

   `include "call_stack_exclusive_time_profiler_unit_defines.svh"

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [FID_W-1:0]   id_ff;
   logic [TS_W-1:0]    ts_ff;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [TS_W-1:0]    dur_ff, dur_in;
   logic [TOT_W-1:0]   excl_ff, excl_in;
   logic               rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]  rsp_user_ff;

   logic               accept;
   logic               fin;
   logic [FID_W-1:0]   req_id;
   logic [TS_W-1:0]    req_ts;
   logic [31:0]        req_id_ext;
   logic [31:0]        id_ext;
   logic               valid_id;

   logic [LVL_W-1:0]   lvl_m1, lvl_m2;
   logic [FRAME_W-1:0] frame_top, frame_par;
   logic [TOT_W-1:0]   total_rd;
   frame_wr_type       frame_wr;
   total_wr_type       total_wr;

   logic [TS_W-1:0]    top_start, top_child, diff;
   logic [TOT_W:0]     total_sum;
   logic [TS_W:0]      child_sum;
   logic [TOT_W-1:0]   total_new, child_new, total_out;
   logic               end_ok, start_ok;

   // request unpacking
   assign req_id     = req_tdata[FID_W-1:0];
   assign req_ts     = req_tdata[FID_W+TS_W-1:FID_W];
   assign req_id_ext = 32'(req_id);
   assign id_ext     = 32'(id_ff);
   assign valid_id   = id_ext < 32'(NUM_FUNCS);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fin        = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_tready);

   // frame pointers: top of stack and its parent
   assign lvl_m1 = level_ff - LVL_W'(1);
   assign lvl_m2 = level_ff - LVL_W'(2);

   cstp_frame_mem u_frame_mem (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (lvl_m1[PTR_W-1:0]),
      .rd_addr_b (lvl_m2[PTR_W-1:0]),
      .rd_data_a (frame_top),
      .rd_data_b (frame_par),
      .wr        (frame_wr)
   );

   cstp_total_mem u_total_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_id_ext[FUNC_AW-1:0]),
      .rd_data (total_rd),
      .wr      (total_wr)
   );

   // stack check at acceptance
   always_comb begin
      case (req_tuser)
         CMD_START: status_in = (level_ff >= LVL_W'(STACK_DEPTH)) ? ST_FULL : ST_OK;
         CMD_END:   status_in = (level_ff == '0) ? ST_EMPTY : ST_OK;
         default:   status_in = ST_OK;
      endcase
   end

   // duration of the popped frame, clamped at zero and at the maximum
   assign top_start = frame_top[FRAME_W-1:TS_W];
   assign top_child = frame_top[TS_W-1:0];
   assign diff      = ts_ff - top_start;

   always_comb begin
      if (ts_ff < top_start) begin
         dur_in = '0;
      end else if (diff == '1) begin
         dur_in = '1;
      end else begin
         dur_in = diff + TS_W'(1);
      end
   end

   assign excl_in = (dur_ff > top_child) ? (dur_ff - top_child) : '0;

   // saturating write-back values
   assign total_sum = {1'b0, total_rd} + {1'b0, excl_ff};
   assign total_new = total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];
   assign child_sum = {1'b0, frame_par[TS_W-1:0]} + {1'b0, dur_ff};
   assign child_new = child_sum[TS_W] ? '1 : child_sum[TS_W-1:0];

   assign start_ok = (cmd_ff == CMD_START) && (status_ff == ST_OK);
   assign end_ok   = (cmd_ff == CMD_END) && (status_ff == ST_OK);

   always_comb begin
      frame_wr = '0;
      total_wr = '0;
      if (fin && start_ok) begin
         frame_wr.en   = 1'b1;
         frame_wr.addr = level_ff[PTR_W-1:0];
         frame_wr.data = {ts_ff, TS_W'(0)};
      end else if (fin && end_ok && (level_ff >= LVL_W'(2))) begin
         frame_wr.en   = 1'b1;
         frame_wr.addr = lvl_m2[PTR_W-1:0];
         frame_wr.data = {frame_par[FRAME_W-1:TS_W], child_new};
      end
      if (fin && end_ok && valid_id) begin
         total_wr.en   = 1'b1;
         total_wr.addr = id_ext[FUNC_AW-1:0];
         total_wr.data = total_new;
      end
   end

   always_comb begin
      if (!valid_id) begin
         total_out = '0;
      end else if (end_ok) begin
         total_out = total_new;
      end else begin
         total_out = total_rd;
      end
   end

   assign rsp_data_in = {(RSP_TDATA_W - FID_W - TOT_W)'(0), total_out, id_ff};

   // sequencer: end events on a non-empty stack go through duration and exclusive steps
   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((req_tuser == CMD_END) && (status_in == ST_OK)) begin
                  state_in = S_DUR;
               end else begin
                  state_in = S_UPD;
               end
            end
         end
         S_DUR:  state_in = S_EXCL;
         S_EXCL: state_in = S_UPD;
         S_UPD: begin
            if (fin) begin
               state_in = S_IDLE;
               if (start_ok) begin
                  level_in = level_ff + LVL_W'(1);
               end else if (end_ok) begin
                  level_in = lvl_m1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         if (fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_tuser;
         id_ff     <= req_id;
         ts_ff     <= req_ts;
         status_ff <= status_in;
      end
      if (state_ff == S_DUR) begin
         dur_ff <= dur_in;
      end
      if (state_ff == S_EXCL) begin
         excl_ff <= excl_in;
      end
      if (fin) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `CSTP_ASSERT_NOW(a_level_bound, clock, reset, 1'b1, level_ff <= LVL_W'(STACK_DEPTH))
   `CSTP_ASSERT_NEXT(a_push_grows, clock, reset, fin && start_ok,
                     level_ff == $past(level_ff) + LVL_W'(1))
   `CSTP_ASSERT_NOW(a_error_no_write, clock, reset, fin && (status_ff != ST_OK),
                    !frame_wr.en && !total_wr.en)
   `CSTP_ASSERT_NOW(a_excl_after_dur, clock, reset, state_ff == S_EXCL,
                    $past(state_ff) == S_DUR)

endmodule

`default_nettype wire

[tb/call_stack_exclusive_time_profiler_unit_tb.sv]
// self-checking bench for the call stack exclusive time profiler
// depends on cstp_pkg and call_stack_exclusive_time_profiler_unit
`timescale 1ns / 100ps

module call_stack_exclusive_time_profiler_unit_tb;
   import cstp_pkg::*;

   // code 3 has no meaning of its own and is taken as a read
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   localparam int DIRECTED_ROWS = 25;
   localparam int PLAN_CEILING  = 200;   // well-formed starts stop at this depth; noise words may push past it
   localparam int IDLE_LIMIT    = 1000;  // cycles without any handshake
   localparam int DRAIN_CYCLES  = 16;    // margin after the drain for stray result words to show up

   typedef logic [FID_W-1:0] fid_type;

   // one request word plus an optional typed-in expectation
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [FID_W-1:0]  fid;
      logic [TS_W-1:0]   ts;
      logic              typed;
      logic [TOT_W-1:0]  total;
      logic [STAT_W-1:0] status;
   } stim_word_type;

   typedef struct packed {
      logic [FID_W-1:0]  fid;
      logic [TOT_W-1:0]  total;
      logic [STAT_W-1:0] status;
   } result_word_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // func_id [6:0], timestamp [38:7], zero [39]
   logic [REQ_TDATA_W-1:0] req_tdata;
   // command [1:0]
   logic [CMD_W-1:0]       req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   // func_out [6:0], total_time [38:7], zero [39]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // status [1:0]
   logic [STAT_W-1:0]      rsp_tuser;

   call_stack_exclusive_time_profiler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor: call stack of frames and the per-function exclusive totals
   // ---------------------------------------------------------------------
   logic [TS_W-1:0]  frame_begin  [STACK_DEPTH];
   logic [TOT_W-1:0] frame_callee [STACK_DEPTH];
   logic [TOT_W-1:0] excl_total   [NUM_FUNCS];
   int               call_depth;

   result_word_type  expected_results [$];
   stim_word_type    pending_words    [$];   // driven words not yet taken
   int               errors = 0;

   function automatic logic [TOT_W-1:0] sat_sum(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
      logic [TOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TOT_W] ? '1 : s[TOT_W-1:0];
   endfunction

   function automatic result_word_type profile_event(input logic [CMD_W-1:0] cmd,
                                                     input fid_type fid,
                                                     input logic [TS_W-1:0] ts);
      result_word_type  r;
      logic [TS_W:0]    span;
      logic [TOT_W-1:0] dur;
      logic [TOT_W-1:0] excl;
      int               top;
      r.fid    = fid;
      r.status = ST_OK;
      case (cmd)
         CMD_START: begin
            if (call_depth >= STACK_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               frame_begin[call_depth]  = ts;
               frame_callee[call_depth] = '0;
               call_depth++;
            end
         end
         CMD_END: begin
            if (call_depth == 0) begin
               r.status = ST_EMPTY;
            end else begin
               top = call_depth - 1;
               // an end stamped before its start counts as no time at all
               span = (ts >= frame_begin[top]) ?
                      {1'b0, ts} - {1'b0, frame_begin[top]} + (TS_W+1)'(1) : '0;
               dur  = span[TS_W] ? '1 : span[TOT_W-1:0];
               excl = (dur > frame_callee[top]) ? dur - frame_callee[top] : '0;
               excl_total[fid] = sat_sum(excl_total[fid], excl);
               call_depth = top;
               if (top > 0) begin
                  frame_callee[top-1] = sat_sum(frame_callee[top-1], dur);
               end
            end
         end
         default: ;   // reads leave everything alone
      endcase
      r.total = excl_total[fid];
      return r;
   endfunction

   // every accepted request word runs through the predictor in order
   always @(posedge clock) begin : take_request
      stim_word_type   note;
      result_word_type want;
      if (!reset && req_tvalid && req_tready) begin
         note = pending_words.pop_front();
         want = profile_event(req_tuser, req_tdata[FID_W-1:0],
                              req_tdata[FID_W+TS_W-1:FID_W]);
         if (note.typed) begin
            want.total  = note.total;
            want.status = note.status;
         end
         expected_results.push_back(want);
      end
   end

   // each result word is held against the oldest expectation
   always @(posedge clock) begin : check_response
      result_word_type  want;
      logic [FID_W-1:0] got_fid;
      logic [TOT_W-1:0] got_total;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_fid   = rsp_tdata[FID_W-1:0];
         got_total = rsp_tdata[FID_W+TOT_W-1:FID_W];
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected word, expected none, got func %0d total %h status %0d",
                     $time, got_fid, got_total, rsp_tuser);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got_fid !== want.fid) begin
               $display("%0t: func_out expected %0d got %0d", $time, want.fid, got_fid);
               errors++;
            end
            if (got_total !== want.total) begin
               $display("%0t: total_time of func %0d expected %h got %h",
                        $time, want.fid, want.total, got_total);
               errors++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status of func %0d expected %0d got %0d",
                        $time, want.fid, want.status, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver back-pressure: a slow cycle through several stall patterns
   // ---------------------------------------------------------------------
   logic [8:0] ready_phase = '0;

   always @(posedge clock) begin
      ready_phase <= ready_phase + 1'b1;
      case (ready_phase[8:6])
         3'd0, 3'd1: rsp_tready <= 1'b1;                        // no stalls at all
         3'd2, 3'd3: rsp_tready <= 1'($urandom_range(0, 1));
         3'd4:       rsp_tready <= (ready_phase[1:0] == 2'd0);  // ready only when ready_phase[1:0] is zero
         3'd5:       rsp_tready <= ready_phase[2];              // follows ready_phase[2]
         default:    rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // watchdog: any handshake counts as progress
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // sender: bursts of words with random gaps; also tracks the stack it
   // builds so that ends can name the function that is on top
   // ---------------------------------------------------------------------
   int               burst_left = 0;
   int               plan_depth = 0;
   fid_type          plan_fids [STACK_DEPTH];
   logic [TS_W-1:0]  tick = '0;

   task automatic send_word(input stim_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      case (w.cmd)
         CMD_START: begin
            if (plan_depth < STACK_DEPTH) begin
               plan_fids[plan_depth] = w.fid;
               plan_depth++;
            end
         end
         CMD_END: begin
            if (plan_depth > 0) plan_depth--;
         end
         default: ;
      endcase
      pending_words.push_back(w);
      req_tvalid <= 1'b1;
      req_tuser  <= w.cmd;
      req_tdata  <= {1'b0, w.ts, w.fid};
      do @(posedge clock); while (!req_tready);
   endtask

   // directed table; typed expectations where the answer is plain, else predicted
   function automatic stim_word_type directed_row(input int i);
      stim_word_type r;
      r = '0;
      case (i)
         // fresh totals read back as zero, an end on the empty stack is refused, the unused code reads too
         0:  r = '{CMD_READ,  7'd0,   32'd0,          1'b1, 32'd0,          ST_OK};
         1:  r = '{CMD_READ,  7'd127, 32'hFFFF_FFFF,  1'b1, 32'd0,          ST_OK};
         2:  r = '{CMD_END,   7'd5,   32'd0,          1'b1, 32'd0,          ST_EMPTY};
         3:  r = '{CMD_SPARE, 7'd42,  32'd0,          1'b1, 32'd0,          ST_OK};
         // nested call: inner spans 20..25, outer loses that span
         4:  r = '{CMD_START, 7'd1,   32'd10,         1'b1, 32'd0,          ST_OK};
         5:  r = '{CMD_START, 7'd2,   32'd20,         1'b1, 32'd0,          ST_OK};
         6:  r = '{CMD_END,   7'd2,   32'd25,         1'b1, 32'd6,          ST_OK};
         7:  r = '{CMD_END,   7'd1,   32'd30,         1'b0, 32'd0,          ST_OK};
         // end stamped before its start adds nothing
         8:  r = '{CMD_START, 7'd3,   32'd100,        1'b1, 32'd0,          ST_OK};
         9:  r = '{CMD_END,   7'd3,   32'd50,         1'b1, 32'd0,          ST_OK};
         // widest span saturates, then the total stays pinned
         10: r = '{CMD_START, 7'd4,   32'd0,          1'b1, 32'd0,          ST_OK};
         11: r = '{CMD_END,   7'd4,   32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_OK};
         12: r = '{CMD_START, 7'd4,   32'd7,          1'b1, 32'hFFFF_FFFF,  ST_OK};
         13: r = '{CMD_END,   7'd4,   32'd9,          1'b1, 32'hFFFF_FFFF,  ST_OK};
         // two huge callees saturate the parent's callee time, which then
         // exceeds the parent's own span
         14: r = '{CMD_START, 7'd6,   32'h8000_0000,  1'b1, 32'd0,          ST_OK};
         15: r = '{CMD_START, 7'd7,   32'd0,          1'b1, 32'd0,          ST_OK};
         16: r = '{CMD_END,   7'd7,   32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_OK};
         17: r = '{CMD_START, 7'd8,   32'd0,          1'b1, 32'd0,          ST_OK};
         18: r = '{CMD_END,   7'd8,   32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_OK};
         19: r = '{CMD_END,   7'd6,   32'h8000_0001,  1'b1, 32'd0,          ST_OK};
         20: r = '{CMD_END,   7'd6,   32'd0,          1'b1, 32'd0,          ST_EMPTY};
         21: r = '{CMD_READ,  7'd1,   32'd0,          1'b0, 32'd0,          ST_OK};
         22: r = '{CMD_READ,  7'd7,   32'hAAAA_5555,  1'b0, 32'd0,          ST_OK};
         // call that starts and ends on the last timestamp of the time range
         23: r = '{CMD_START, 7'd127, 32'hFFFF_FFFF,  1'b0, 32'd0,          ST_OK};
         default: r = '{CMD_END, 7'd127, 32'hFFFF_FFFF, 1'b0, 32'd0,        ST_OK};
      endcase
      return r;
   endfunction

   // mostly well-formed call nesting with random content, some reads, some noise
   task automatic random_events(input int count);
      stim_word_type w;
      int            pick;
      w = '0;
      repeat (count) begin
         pick  = $urandom_range(0, 99);
         w.fid = fid_type'($urandom_range(0, NUM_FUNCS - 1));
         tick += ($urandom_range(0, 31) == 0) ? $urandom() : $urandom_range(0, 40);
         w.ts  = tick;
         if (pick < 80) begin
            if (plan_depth == 0 || (plan_depth < PLAN_CEILING && pick < 42)) begin
               w.cmd = CMD_START;
            end else begin
               w.cmd = CMD_END;
               // now and then the end names some other function
               if (pick < 78) w.fid = plan_fids[plan_depth-1];
            end
         end else if (pick < 92) begin
            w.cmd = (pick < 90) ? CMD_READ : CMD_SPARE;
         end else begin
            w.cmd = CMD_W'($urandom_range(0, 3));
            w.ts  = $urandom();
         end
         send_word(w);
      end
   endtask

   // ---------------------------------------------------------------------
   // run
   // ---------------------------------------------------------------------
   initial begin : run
      stim_word_type w;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_READ;
      call_depth = 0;
      for (int f = 0; f < NUM_FUNCS; f++) excl_total[f] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) send_word(directed_row(i));

      random_events(400);

      // fill the stack to the brim and push past it, then unwind every frame
      // and pop once more on the empty stack
      w = '0;
      repeat (STACK_DEPTH + 2) begin
         tick += $urandom_range(1, 8);
         w.cmd = CMD_START;
         w.fid = fid_type'($urandom_range(0, NUM_FUNCS - 1));
         w.ts  = tick;
         send_word(w);
      end
      repeat (STACK_DEPTH + 1) begin
         tick += $urandom_range(0, 8);
         w.cmd = CMD_END;
         w.fid = (plan_depth > 0) ? plan_fids[plan_depth-1]
                                  : fid_type'($urandom_range(0, NUM_FUNCS - 1));
         w.ts  = tick;
         send_word(w);
      end

      random_events(430);
      req_tvalid <= 1'b0;

      // drain, then give stray words a chance to show up
      while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
